[rtl/matrix_2x2_eigen_decomposition_defines.svh]
// Assertion macros for the checker of the 2x2 eigen decomposition block.
`ifndef MATRIX_2X2_EIGEN_DECOMPOSITION_DEFINES_SVH
`define MATRIX_2X2_EIGEN_DECOMPOSITION_DEFINES_SVH

// The consequent must hold in the cycle in which the antecedent is seen.
`define M2E_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The condition must never be seen outside of reset.
`define M2E_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`endif

[rtl/m2eig_pkg.sv]
// Shared constants and the latency function of the 2x2 eigen decomposition block.
package m2eig_pkg;

  localparam int unsigned ENTRY_W = 32;
  localparam int unsigned VEC_W = 18;
  localparam int unsigned TOL_W = 31;
  localparam logic [TOL_W-1:0] TOL_RESET = 31'd66;
  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned NORM_W = 30;
  localparam int unsigned SQ1_W = 32;
  localparam int unsigned SQ2_W = 31;

  // Cycles from the accepting edge to the edge that takes the result.
  function automatic int unsigned m2eig_latency(int unsigned frac);
    return 3 + SQ1_W + 5 + SQ2_W + (frac + 1) + 1;
  endfunction

endpackage

[rtl/m2eig_isqrt.sv]
// Pipelined integer square root, one root bit resolved per register stage.
module m2eig_isqrt #(
  parameter int unsigned ROOT_W = m2eig_pkg::SQ1_W
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  logic [2*ROOT_W-1:0]   rad_i,
  output logic                  valid_o,
  output logic [ROOT_W-1:0]     root_o
);
  import m2eig_pkg::*;

  logic [ROOT_W:0]     rem_q  [ROOT_W];
  logic [ROOT_W-1:0]   root_q [ROOT_W];
  logic [2*ROOT_W-1:0] rad_q  [ROOT_W];
  logic                vld_q  [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_step
    logic [ROOT_W:0]     rem_in;
    logic [ROOT_W-1:0]   root_in;
    logic [2*ROOT_W-1:0] rad_in;
    logic                vld_in;
    logic [ROOT_W+2:0]   r2;
    logic [ROOT_W+2:0]   trial;
    logic [ROOT_W+2:0]   diff;
    logic                take;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad_i;
      assign vld_in  = valid_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign rad_in  = rad_q[k-1];
      assign vld_in  = vld_q[k-1];
    end

    // Bring down the next two radicand bits and try the digit one.
    assign r2    = {rem_in, rad_in[2*ROOT_W-1 -: 2]};
    assign trial = {1'b0, root_in, 2'b01};
    assign diff  = r2 - trial;
    assign take  = (r2 >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[k]  <= take ? diff[ROOT_W:0] : r2[ROOT_W:0];
      root_q[k] <= {root_in[ROOT_W-2:0], take};
      rad_q[k]  <= {rad_in[2*ROOT_W-3:0], 2'b00};
    end
  end

  assign valid_o = vld_q[ROOT_W-1];
  assign root_o  = root_q[ROOT_W-1];

endmodule

[rtl/matrix_2x2_eigen_decomposition.sv]
// Top level of the 2x2 eigen decomposition pipeline.
//
// Channel   Direction  Signals                                     Transfer
// request   in         start_i, busy_o, a00_i..a11_i               start_i && !busy_o
// config    in         cfg_valid_i, cfg_ready_o, cfg_tolerance_i   cfg_valid_i && cfg_ready_o
// result    out        done_o, lambda_*_o, *_vec_*_o, flags        done_o, one cycle
//
// A request is taken in every cycle; busy_o is held low because nothing ever stalls.
// Each request produces one result; its path runs through the discriminant square
// root (32 stages), the norm square roots (31 stages) and the restoring dividers
// (FRAC_BITS + 1 stages).
// Reset clears the valid bits of all stages and loads the tolerance with 66.
// The receiver cannot stall; results leave on done_o without any backpressure.
module matrix_2x2_eigen_decomposition #(
  parameter int unsigned FRAC_BITS = m2eig_pkg::FRAC_BITS_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start_i,
  output logic                                   busy_o,
  input  logic signed [m2eig_pkg::ENTRY_W-1:0]   a00_i,
  input  logic signed [m2eig_pkg::ENTRY_W-1:0]   a01_i,
  input  logic signed [m2eig_pkg::ENTRY_W-1:0]   a10_i,
  input  logic signed [m2eig_pkg::ENTRY_W-1:0]   a11_i,
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [m2eig_pkg::TOL_W-1:0]            cfg_tolerance_i,
  output logic                                   done_o,
  output logic signed [m2eig_pkg::ENTRY_W-1:0]   lambda_major_o,
  output logic signed [m2eig_pkg::ENTRY_W-1:0]   lambda_minor_o,
  output logic signed [m2eig_pkg::VEC_W-1:0]     first_vec_x_o,
  output logic signed [m2eig_pkg::VEC_W-1:0]     first_vec_y_o,
  output logic signed [m2eig_pkg::VEC_W-1:0]     second_vec_x_o,
  output logic signed [m2eig_pkg::VEC_W-1:0]     second_vec_y_o,
  output logic                                   complex_flag_o,
  output logic                                   degenerate_flag_o
);
  import m2eig_pkg::*;

  // Sideband that rides along the discriminant square root.
  typedef struct packed {
    logic signed [31:0] a00;
    logic signed [31:0] a01;
    logic signed [31:0] a10;
    logic signed [31:0] a11;
    logic signed [32:0] tr;
    logic               diag;
    logic               use10;
    logic               cplx;
  } sb1_t;

  // Eigenvalues and vector status that ride along the norm and divide stages.
  typedef struct packed {
    logic signed [33:0] lmaj;
    logic signed [33:0] lmin;
    logic [3:0]         neg;
    logic [1:0]         zero;
    logic               cplx;
  } sbo_t;

  typedef struct packed {
    sbo_t                   o;
    logic [3:0][NORM_W-1:0] m;
  } sb2_t;

  // The pipeline never stalls, so both handshakes are always open.
  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;

  // Tolerance register.
  logic [TOL_W-1:0] tol_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= TOL_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      tol_q <= cfg_tolerance_i;
    end
  end

  // Stage A: capture the request together with the tolerance it is judged by.
  logic               va_q;
  logic signed [31:0] a00_q, a01_q, a10_q, a11_q;
  logic [TOL_W-1:0]   tol_a_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else begin
      va_q <= start_i && !busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    a00_q   <= a00_i;
    a01_q   <= a01_i;
    a10_q   <= a10_i;
    a11_q   <= a11_i;
    tol_a_q <= tol_q;
  end

  // Stage B: off-diagonal tests, trace, and the two products of the discriminant.
  logic [31:0]        m01_b, m10_b, hd_b;
  logic signed [32:0] dif_b, tr_b;
  logic [32:0]        dneg_b;
  logic signed [63:0] prod_d;
  logic [63:0]        hdsq_d;

  assign m01_b  = a01_q[31] ? (~a01_q + 32'd1) : a01_q;
  assign m10_b  = a10_q[31] ? (~a10_q + 32'd1) : a10_q;
  assign tr_b   = {a00_q[31], a00_q} + {a11_q[31], a11_q};
  assign dif_b  = {a00_q[31], a00_q} - {a11_q[31], a11_q};
  assign dneg_b = ~dif_b + 33'd1;
  assign hd_b   = dif_b[32] ? dneg_b[31:0] : dif_b[31:0];
  assign prod_d = a01_q * a10_q;
  assign hdsq_d = hd_b * hd_b;

  logic               vb_q;
  logic signed [63:0] prod_q;
  logic [63:0]        hdsq_q;
  sb1_t               sb_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
    end else begin
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q       <= prod_d;
    hdsq_q       <= hdsq_d;
    sb_b_q.a00   <= a00_q;
    sb_b_q.a01   <= a01_q;
    sb_b_q.a10   <= a10_q;
    sb_b_q.a11   <= a11_q;
    sb_b_q.tr    <= tr_b;
    sb_b_q.diag  <= (m01_b < {1'b0, tol_a_q}) && (m10_b < {1'b0, tol_a_q});
    sb_b_q.use10 <= (m10_b > {1'b0, tol_a_q});
    sb_b_q.cplx  <= 1'b0;
  end

  // Stage C: discriminant; a negative one is flagged and its root taken as zero.
  // The diagonal shortcut never uses the discriminant, so it is never flagged.
  logic signed [63:0] disc_c;
  assign disc_c = $signed({2'b00, hdsq_q[63:2]}) + prod_q;

  sb1_t sb_c_d;
  always_comb begin
    sb_c_d      = sb_b_q;
    sb_c_d.cplx = disc_c[63] && !sb_b_q.diag;
  end

  logic                 vc_q;
  logic [2*SQ1_W-1:0]   rad_c_q;
  sb1_t                 sb_c_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q <= 1'b0;
    end else begin
      vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_c_q <= disc_c[63] ? '0 : disc_c;
    sb_c_q  <= sb_c_d;
  end

  // Discriminant root, with the sideband delayed to match.
  logic              sq1_v;
  logic [SQ1_W-1:0]  root;
  sb1_t              sb1_q [SQ1_W];

  m2eig_isqrt #(
    .ROOT_W (SQ1_W)
  ) u_sqrt_disc (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vc_q),
    .rad_i   (rad_c_q),
    .valid_o (sq1_v),
    .root_o  (root)
  );

  always_ff @(posedge clk_i) begin
    sb1_q[0] <= sb_c_q;
    for (int k = 1; k < SQ1_W; k++) begin
      sb1_q[k] <= sb1_q[k-1];
    end
  end

  sb1_t sbd;
  assign sbd = sb1_q[SQ1_W-1];

  // Stage D: eigenvalues as floor((T +- 2r) / 2), exact and unsaturated, or the diagonal entries on the shortcut.
  logic signed [34:0] trx_d, two_r_d, s0_d, s1_d;
  assign trx_d   = {{2{sbd.tr[32]}}, sbd.tr};
  assign two_r_d = {2'b00, root, 1'b0};
  assign s0_d    = trx_d + two_r_d;
  assign s1_d    = trx_d - two_r_d;

  logic               vd_q;
  logic signed [33:0] l0_q, l1_q;
  sb1_t               sb_d_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vd_q <= 1'b0;
    end else begin
      vd_q <= sq1_v;
    end
  end

  always_ff @(posedge clk_i) begin
    l0_q   <= sbd.diag ? {{2{sbd.a00[31]}}, sbd.a00} : s0_d[34:1];
    l1_q   <= sbd.diag ? {{2{sbd.a11[31]}}, sbd.a11} : s1_d[34:1];
    sb_d_q <= sbd;
  end

  // Stage E: raw eigenvectors and ordering by magnitude (ties keep the order).
  logic signed [34:0] l0x_e, l1x_e, a00x_e, a01x_e, a10x_e, a11x_e;
  logic signed [34:0] x0_e, y0_e, x1_e, y1_e;
  logic [33:0]        ml0_e, ml1_e;
  logic               swap_e;

  assign l0x_e  = {l0_q[33], l0_q};
  assign l1x_e  = {l1_q[33], l1_q};
  assign a00x_e = {{3{sb_d_q.a00[31]}}, sb_d_q.a00};
  assign a01x_e = {{3{sb_d_q.a01[31]}}, sb_d_q.a01};
  assign a10x_e = {{3{sb_d_q.a10[31]}}, sb_d_q.a10};
  assign a11x_e = {{3{sb_d_q.a11[31]}}, sb_d_q.a11};
  assign ml0_e  = l0_q[33] ? (~l0_q + 34'd1) : l0_q;
  assign ml1_e  = l1_q[33] ? (~l1_q + 34'd1) : l1_q;
  assign swap_e = (ml0_e < ml1_e);

  always_comb begin
    if (sb_d_q.diag) begin
      x0_e = 35'sd1;
      y0_e = 35'sd0;
      x1_e = 35'sd0;
      y1_e = 35'sd1;
    end else if (sb_d_q.use10) begin
      x0_e = l0x_e - a11x_e;
      y0_e = a10x_e;
      x1_e = l1x_e - a11x_e;
      y1_e = a10x_e;
    end else begin
      x0_e = a01x_e;
      y0_e = l0x_e - a00x_e;
      x1_e = a01x_e;
      y1_e = l1x_e - a00x_e;
    end
  end

  logic               ve_q;
  logic signed [33:0] lmaj_e_q, lmin_e_q;
  logic signed [34:0] vx0_q, vy0_q, vx1_q, vy1_q;
  logic               cplx_e_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ve_q <= 1'b0;
    end else begin
      ve_q <= vd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    lmaj_e_q <= swap_e ? l1_q : l0_q;
    lmin_e_q <= swap_e ? l0_q : l1_q;
    vx0_q    <= swap_e ? x1_e : x0_e;
    vy0_q    <= swap_e ? y1_e : y0_e;
    vx1_q    <= swap_e ? x0_e : x1_e;
    vy1_q    <= swap_e ? y0_e : y1_e;
    cplx_e_q <= sb_d_q.cplx;
  end

  // Stage F: magnitudes, zero test and the common scaling below 2^30.
  logic [3:0][34:0]  mag_f;
  logic [3:0]        neg_f;
  logic [1:0][34:0]  or_f;
  logic [1:0][2:0]   sh_f;
  logic [3:0][34:0]  msh_f;

  always_comb begin
    neg_f = {vy1_q[34], vx1_q[34], vy0_q[34], vx0_q[34]};
    mag_f[0] = vx0_q[34] ? (~vx0_q + 35'd1) : vx0_q;
    mag_f[1] = vy0_q[34] ? (~vy0_q + 35'd1) : vy0_q;
    mag_f[2] = vx1_q[34] ? (~vx1_q + 35'd1) : vx1_q;
    mag_f[3] = vy1_q[34] ? (~vy1_q + 35'd1) : vy1_q;
    for (int v = 0; v < 2; v++) begin
      or_f[v] = mag_f[2*v] | mag_f[2*v+1];
      if (or_f[v][34]) begin
        sh_f[v] = 3'd5;
      end else if (or_f[v][33]) begin
        sh_f[v] = 3'd4;
      end else if (or_f[v][32]) begin
        sh_f[v] = 3'd3;
      end else if (or_f[v][31]) begin
        sh_f[v] = 3'd2;
      end else if (or_f[v][30]) begin
        sh_f[v] = 3'd1;
      end else begin
        sh_f[v] = 3'd0;
      end
    end
    for (int i = 0; i < 4; i++) begin
      msh_f[i] = mag_f[i] >> sh_f[i/2];
    end
  end

  logic                   vf_q;
  logic [3:0][NORM_W-1:0] m_f_q;
  sbo_t                   sbo_f_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vf_q <= 1'b0;
    end else begin
      vf_q <= ve_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 4; i++) begin
      m_f_q[i] <= msh_f[i][NORM_W-1:0];
    end
    sbo_f_q.lmaj <= lmaj_e_q;
    sbo_f_q.lmin <= lmin_e_q;
    sbo_f_q.neg  <= neg_f;
    sbo_f_q.zero <= {(or_f[1] == '0), (or_f[0] == '0)};
    sbo_f_q.cplx <= cplx_e_q;
  end

  // Stage G: squares of the scaled components.
  logic                     vg_q;
  logic [3:0][2*NORM_W-1:0] sq_g_q;
  sb2_t                     sb_g_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vg_q <= 1'b0;
    end else begin
      vg_q <= vf_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 4; i++) begin
      sq_g_q[i] <= m_f_q[i] * m_f_q[i];
    end
    sb_g_q.o <= sbo_f_q;
    sb_g_q.m <= m_f_q;
  end

  // Stage H: squared norms.
  logic                     vh_q;
  logic [1:0][2*SQ2_W-1:0]  nsq_h_q;
  sb2_t                     sb_h_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vh_q <= 1'b0;
    end else begin
      vh_q <= vg_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int v = 0; v < 2; v++) begin
      nsq_h_q[v] <= {2'b00, sq_g_q[2*v]} + {2'b00, sq_g_q[2*v+1]};
    end
    sb_h_q <= sb_g_q;
  end

  // Norm roots for both vectors.
  logic                   sq2_v;
  logic [1:0][SQ2_W-1:0]  nrm;
  sb2_t                   sb2_q [SQ2_W];

  m2eig_isqrt #(
    .ROOT_W (SQ2_W)
  ) u_sqrt_norm0 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vh_q),
    .rad_i   (nsq_h_q[0]),
    .valid_o (sq2_v),
    .root_o  (nrm[0])
  );

  m2eig_isqrt #(
    .ROOT_W (SQ2_W)
  ) u_sqrt_norm1 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vh_q),
    .rad_i   (nsq_h_q[1]),
    .valid_o (),
    .root_o  (nrm[1])
  );

  always_ff @(posedge clk_i) begin
    sb2_q[0] <= sb_h_q;
    for (int k = 1; k < SQ2_W; k++) begin
      sb2_q[k] <= sb2_q[k-1];
    end
  end

  // Restoring dividers: (m << FRAC_BITS) / n, one quotient bit per stage.
  // The quotient never exceeds 2^FRAC_BITS, so FRAC_BITS + 1 steps suffice and
  // the starting remainder is m >> 1.
  localparam int unsigned DSTG = FRAC_BITS + 1;
  localparam int unsigned RW = SQ2_W + 1;

  logic [3:0][RW-1:0]       dv_rem_q [DSTG];
  logic [3:0][FRAC_BITS:0]  dv_q_q   [DSTG];
  logic [1:0][SQ2_W-1:0]    dv_n_q   [DSTG];
  sbo_t                     dv_sb_q  [DSTG];
  logic                     dv_v_q   [DSTG];

  for (genvar k = 0; k < DSTG; k++) begin : g_div
    logic [3:0][RW-1:0]      rem_in;
    logic [3:0][FRAC_BITS:0] q_in;
    logic [1:0][SQ2_W-1:0]   n_in;
    logic [3:0]              bit_in;
    sbo_t                    sb_in;
    logic                    v_in;
    logic [3:0][RW-1:0]      rem_d;
    logic [3:0][FRAC_BITS:0] q_d;

    if (k == 0) begin : g_first
      sb2_t sb_last;
      assign sb_last = sb2_q[SQ2_W-1];
      for (genvar i = 0; i < 4; i++) begin : g_lane
        assign rem_in[i] = {{(RW-NORM_W+1){1'b0}}, sb_last.m[i][NORM_W-1:1]};
        assign bit_in[i] = sb_last.m[i][0];
      end
      assign q_in  = '0;
      assign n_in  = nrm;
      assign sb_in = sb_last.o;
      assign v_in  = sq2_v;
    end else begin : g_next
      assign rem_in = dv_rem_q[k-1];
      assign bit_in = '0;
      assign q_in   = dv_q_q[k-1];
      assign n_in   = dv_n_q[k-1];
      assign sb_in  = dv_sb_q[k-1];
      assign v_in   = dv_v_q[k-1];
    end

    always_comb begin
      logic [RW-1:0] r2;
      logic [RW-1:0] nn;
      for (int i = 0; i < 4; i++) begin
        r2 = {rem_in[i][RW-2:0], bit_in[i]};
        nn = {1'b0, n_in[i/2]};
        if (r2 >= nn) begin
          rem_d[i] = r2 - nn;
          q_d[i]   = {q_in[i][FRAC_BITS-1:0], 1'b1};
        end else begin
          rem_d[i] = r2;
          q_d[i]   = {q_in[i][FRAC_BITS-1:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_v_q[k] <= 1'b0;
      end else begin
        dv_v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      dv_rem_q[k] <= rem_d;
      dv_q_q[k]   <= q_d;
      dv_n_q[k]   <= n_in;
      dv_sb_q[k]  <= sb_in;
    end
  end

  // Output stage: saturation of the eigenvalues and signs of the components.
  sbo_t                    sb_o;
  logic [3:0][FRAC_BITS:0] q_o;
  logic [3:0][31:0]        qe_o;
  logic [3:0][31:0]        comp_o;

  assign sb_o = dv_sb_q[DSTG-1];
  assign q_o  = dv_q_q[DSTG-1];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      qe_o[i] = {{(31 - FRAC_BITS){1'b0}}, q_o[i]};
      if (sb_o.zero[i/2]) begin
        comp_o[i] = '0;
      end else if (sb_o.neg[i]) begin
        comp_o[i] = ~qe_o[i] + 32'd1;
      end else begin
        comp_o[i] = qe_o[i];
      end
    end
  end

  function automatic logic [31:0] sat32(logic signed [33:0] v);
    logic [31:0] r;
    if ((v[33:31] == 3'b000) || (v[33:31] == 3'b111)) begin
      r = v[31:0];
    end else if (v[33]) begin
      r = 32'h8000_0000;
    end else begin
      r = 32'h7FFF_FFFF;
    end
    return r;
  endfunction

  logic done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= dv_v_q[DSTG-1];
    end
  end

  always_ff @(posedge clk_i) begin
    lambda_major_o    <= sat32(sb_o.lmaj);
    lambda_minor_o    <= sat32(sb_o.lmin);
    first_vec_x_o     <= comp_o[0][VEC_W-1:0];
    first_vec_y_o     <= comp_o[1][VEC_W-1:0];
    second_vec_x_o    <= comp_o[2][VEC_W-1:0];
    second_vec_y_o    <= comp_o[3][VEC_W-1:0];
    complex_flag_o    <= sb_o.cplx;
    degenerate_flag_o <= sb_o.zero[0] | sb_o.zero[1];
  end

  assign done_o = done_q;

endmodule

[rtl/m2eig_checker.sv]
// Port-level checker of the 2x2 eigen decomposition block and its bind.
`include "matrix_2x2_eigen_decomposition_defines.svh"

module m2eig_checker #(
  parameter int unsigned FRAC_BITS = m2eig_pkg::FRAC_BITS_DEF
) (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 start_i,
  input logic                                 busy_o,
  input logic                                 done_o,
  input logic signed [m2eig_pkg::ENTRY_W-1:0] lambda_major_o,
  input logic signed [m2eig_pkg::ENTRY_W-1:0] lambda_minor_o,
  input logic signed [m2eig_pkg::VEC_W-1:0]   first_vec_x_o,
  input logic signed [m2eig_pkg::VEC_W-1:0]   first_vec_y_o,
  input logic                                 complex_flag_o,
  input logic                                 degenerate_flag_o
);
  import m2eig_pkg::*;

  localparam int unsigned LAT = m2eig_latency(FRAC_BITS);

  // Every result traces back to a request that the block accepted.
  `M2E_ASSERT_IMPLY(a_result_has_request, clk_i, rst_ni, done_o, $past(start_i && !busy_o, LAT), "result without a matching request")

  // A forced zero root gives two equal eigenvalues.
  `M2E_ASSERT_IMPLY(a_complex_equal, clk_i, rst_ni, done_o && complex_flag_o, lambda_major_o == lambda_minor_o, "complex result with unequal eigenvalues")

  // The block never refuses a request.
  `M2E_ASSERT_NEVER(a_never_busy, clk_i, rst_ni, busy_o, "busy raised")

  if (FRAC_BITS <= 17) begin : g_vec
    // A vector that was not degenerate has a nonzero unit form.
    `M2E_ASSERT_IMPLY(a_vec_nonzero, clk_i, rst_ni, done_o && !degenerate_flag_o, (first_vec_x_o != 0) || (first_vec_y_o != 0), "zero vector without degenerate flag")
  end

endmodule

bind matrix_2x2_eigen_decomposition m2eig_checker #(
  .FRAC_BITS (FRAC_BITS)
) u_m2eig_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .start_i           (start_i),
  .busy_o            (busy_o),
  .done_o            (done_o),
  .lambda_major_o    (lambda_major_o),
  .lambda_minor_o    (lambda_minor_o),
  .first_vec_x_o     (first_vec_x_o),
  .first_vec_y_o     (first_vec_y_o),
  .complex_flag_o    (complex_flag_o),
  .degenerate_flag_o (degenerate_flag_o)
);

[bench/testbench.sv]
// Self-checking testbench for the 2x2 eigen decomposition pipeline.
module testbench;
  import m2eig_pkg::*;

  localparam int unsigned FRAC = FRAC_BITS_DEF;
  localparam int unsigned LAT = m2eig_latency(FRAC);
  localparam longint unsigned CYCLE_LIMIT = 400000;

  // One result of the block, fields at port widths.
  typedef struct packed {
    logic [ENTRY_W-1:0] lam_major;
    logic [ENTRY_W-1:0] lam_minor;
    logic [VEC_W-1:0]   v1x;
    logic [VEC_W-1:0]   v1y;
    logic [VEC_W-1:0]   v2x;
    logic [VEC_W-1:0]   v2y;
    logic               cplx;
    logic               degen;
  } eigen_res_t;

  // Predicts eigen results for accepted requests and checks what comes out.
  class eigen_scoreboard;
    eigen_res_t pending[$];
    longint unsigned tol = TOL_RESET;
    int unsigned errors = 0;
    int unsigned checked = 0;
    int unsigned n_cplx = 0;
    int unsigned n_degen = 0;
    int unsigned n_diag = 0;

    function automatic longint unsigned mag(longint v);
      return v < 0 ? longint'(-v) : longint'(v);
    endfunction

    function automatic longint floor_half(longint v);
      return v >= 0 ? v / 2 : -((-v + 1) / 2);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned x);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > x) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (x >= res + bitv) begin
          x = x - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
      return res;
    endfunction

    function automatic longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    // Scales a raw vector to unit length; a zero vector stays zero and is flagged.
    function automatic void unit_vec(input longint x, input longint y,
                                     output longint ox, output longint oy,
                                     inout bit degen);
      longint unsigned mx, my, n;
      mx = mag(x);
      my = mag(y);
      if (mx == 0 && my == 0) begin
        ox = 0;
        oy = 0;
        degen = 1;
        return;
      end
      while (mx >= (64'd1 << 30) || my >= (64'd1 << 30)) begin
        mx = mx >> 1;
        my = my >> 1;
      end
      n = int_sqrt(mx * mx + my * my);
      ox = longint'((mx << FRAC) / n);
      oy = longint'((my << FRAC) / n);
      if (x < 0) ox = -ox;
      if (y < 0) oy = -oy;
    endfunction

    function automatic void note_request(logic signed [31:0] e00, logic signed [31:0] e01,
                                         logic signed [31:0] e10, logic signed [31:0] e11);
      longint a00, a01, a10, a11, l0, l1, x0, y0, x1, y1, t, tr, disc, root;
      longint q0, q1, q2, q3;
      longint unsigned m01, m10, hd;
      bit cplx, degen;
      eigen_res_t r;
      a00 = e00; a01 = e01; a10 = e10; a11 = e11;
      cplx = 0;
      degen = 0;
      m01 = mag(a01);
      m10 = mag(a10);
      if (m01 < tol && m10 < tol) begin
        // Off-diagonal counts as zero: diagonal values, identity vectors.
        l0 = a00; l1 = a11;
        x0 = 1; y0 = 0; x1 = 0; y1 = 1;
        n_diag++;
      end else begin
        tr = a00 + a11;
        hd = mag(a00 - a11);
        disc = longint'((hd * hd) >> 2) + a01 * a10;
        root = 0;
        if (disc < 0) cplx = 1;
        else root = longint'(int_sqrt(longint'(disc)));
        l0 = floor_half(tr + 2 * root);
        l1 = floor_half(tr - 2 * root);
        if (m10 > tol) begin
          x0 = l0 - a11; y0 = a10; x1 = l1 - a11; y1 = a10;
        end else begin
          x0 = a01; y0 = l0 - a00; x1 = a01; y1 = l1 - a00;
        end
      end
      if (mag(l0) < mag(l1)) begin
        t = l0; l0 = l1; l1 = t;
        t = x0; x0 = x1; x1 = t;
        t = y0; y0 = y1; y1 = t;
      end
      unit_vec(x0, y0, q0, q1, degen);
      unit_vec(x1, y1, q2, q3, degen);
      r.lam_major = ENTRY_W'(clamp32(l0));
      r.lam_minor = ENTRY_W'(clamp32(l1));
      r.v1x = VEC_W'(q0); r.v1y = VEC_W'(q1); r.v2x = VEC_W'(q2); r.v2y = VEC_W'(q3);
      r.cplx = cplx;
      r.degen = degen;
      if (cplx) n_cplx++;
      if (degen) n_degen++;
      pending.push_back(r);
    endfunction

    function automatic void cmp(string name, longint unsigned e, longint unsigned a);
      if (e != a) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, e, a);
        errors++;
      end
    endfunction

    function automatic void check_result(eigen_res_t act);
      eigen_res_t e;
      if (pending.size() == 0) begin
        $error("result arrived with no request outstanding");
        errors++;
        return;
      end
      e = pending.pop_front();
      checked++;
      cmp("lambda_major", e.lam_major, act.lam_major);
      cmp("lambda_minor", e.lam_minor, act.lam_minor);
      cmp("first_vec_x", e.v1x, act.v1x);
      cmp("first_vec_y", e.v1y, act.v1y);
      cmp("second_vec_x", e.v2x, act.v2x);
      cmp("second_vec_y", e.v2y, act.v2y);
      cmp("complex_flag", e.cplx, act.cplx);
      cmp("degenerate_flag", e.degen, act.degen);
    endfunction
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  logic start_i = 0;
  logic busy_o;
  logic signed [ENTRY_W-1:0] a00_i = '0, a01_i = '0, a10_i = '0, a11_i = '0;
  logic cfg_valid_i = 0;
  logic cfg_ready_o;
  logic [TOL_W-1:0] cfg_tolerance_i = '0;
  logic done_o;
  logic signed [ENTRY_W-1:0] lambda_major_o, lambda_minor_o;
  logic signed [VEC_W-1:0] first_vec_x_o, first_vec_y_o, second_vec_x_o, second_vec_y_o;
  logic complex_flag_o, degenerate_flag_o;

  eigen_scoreboard sb = new();
  longint unsigned cycles = 0;
  int unsigned accepted = 0;
  bit allow_gaps = 1;

  matrix_2x2_eigen_decomposition dut (.*);

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  // Monitor: requests and results are both taken at the rising edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_o) sb.note_request(a00_i, a01_i, a10_i, a11_i);
      if (done_o)
        sb.check_result({lambda_major_o, lambda_minor_o, first_vec_x_o, first_vec_y_o,
                         second_vec_x_o, second_vec_y_o, complex_flag_o,
                         degenerate_flag_o});
    end
  end

  // Watchdog on total run length.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Presents one matrix, after an optional random gap, and holds it until the block takes it.
  task automatic send_matrix(logic [31:0] e00, logic [31:0] e01,
                             logic [31:0] e10, logic [31:0] e11);
    int unsigned gap;
    if (allow_gaps && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 10);
      start_i = 0;
      repeat (gap) @(negedge clk_i);
    end
    start_i = 1;
    a00_i = e00; a01_i = e01; a10_i = e10; a11_i = e11;
    do @(posedge clk_i); while (busy_o);
    accepted++;
    @(negedge clk_i);
    start_i = 0;
  endtask

  // Lets every outstanding request drain, plus the pipeline depth.
  task automatic drain();
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (LAT + 4) @(negedge clk_i);
  endtask

  task automatic write_tolerance(logic [TOL_W-1:0] value);
    cfg_valid_i = 1;
    cfg_tolerance_i = value;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.tol = value;
    @(negedge clk_i);
    cfg_valid_i = 0;
  endtask

  // Random matrix of a chosen flavor: full range, small entries, or near tolerance.
  task automatic send_random();
    logic [31:0] e[4];
    int unsigned kind;
    kind = $urandom_range(0, 9);
    for (int i = 0; i < 4; i++) begin
      case (kind)
        0, 1, 2: e[i] = $urandom();
        3, 4, 5, 6: e[i] = $signed($urandom_range(0, 20 << 16)) - (10 << 16);
        default: e[i] = $signed($urandom_range(0, 1 << 18)) - (1 << 17);
      endcase
    end
    if (kind >= 7) begin
      // Off-diagonal entries straddle the current tolerance.
      e[1] = $urandom_range(0, 1) ? 32'(sb.tol + $urandom_range(0, 2) - 1) : 0;
      e[2] = $urandom_range(0, 1) ? 32'(-(sb.tol + $urandom_range(0, 2) - 1)) : 0;
      if ($urandom_range(0, 3) == 0) e[3] = e[0];
    end
    send_matrix(e[0], e[1], e[2], e[3]);
  endtask

  initial begin
    logic [TOL_W-1:0] tols[6];
    repeat (10) @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);

    // Directed part at the reset tolerance.
    allow_gaps = 0;
    send_matrix(32'h0001_0000, 0, 0, 32'h0002_0000);         // diagonal, below tolerance
    send_matrix(32'h0000_5000, 0, 0, 32'hFFFF_B000);         // equal magnitudes keep order
    send_matrix(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_matrix(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_matrix(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    send_matrix(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    send_matrix(0, 32'h0001_0000, 32'hFFFF_0000, 0);         // rotation: complex roots
    send_matrix(32'h0003_0000, 32'h0001_0000, 32'h0001_0000, 32'h0003_0000);
    send_matrix(32'h0002_0000, 0, 32'd66, 32'h0002_0000);     // lower-left at tolerance: zero vectors
    send_matrix(32'h0002_0000, 32'd66, 0, 32'h0001_0000);     // upper-right path
    send_matrix(32'h0002_0000, 32'd65, 32'd65, 32'h0001_0000);
    send_matrix(32'hFFFF_FFFF, 32'hFFFF_FF00, 32'd67, 32'h8000_0000);
    send_matrix(32'h8000_0000, 0, 32'h8000_0000, 32'h7FFF_FFFF);
    send_matrix(0, 0, 0, 0);
    send_matrix(32'h0001_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_0000);
    allow_gaps = 1;
    drain();

    // Random phases, each at its own tolerance including the extremes.
    tols[0] = 0;
    tols[1] = 31'h7FFF_FFFF;
    tols[2] = 31'd66;
    tols[3] = 31'h0001_0000;
    tols[4] = TOL_W'($urandom());
    tols[5] = TOL_W'($urandom_range(0, 4096));
    for (int p = 0; p < 6; p++) begin
      write_tolerance(tols[p]);
      if (p == 5) allow_gaps = 0;
      for (int i = 0; i < 280; i++) begin
        send_random();
        // Hold off once until everything in flight has come back.
        if (p == 2 && i == 140)
          while (sb.pending.size() != 0) @(negedge clk_i);
      end
      drain();
    end

    $display("%0d matrices accepted, %0d results checked over 7 tolerance settings",
             accepted, sb.checked);
    $display("%0d diagonal shortcuts, %0d complex, %0d with zero vectors",
             sb.n_diag, sb.n_cplx, sb.n_degen);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      if (sb.pending.size() != 0) $error("%0d results never arrived", sb.pending.size());
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[matrix_2x2_eigen_decomposition.f]
+incdir+rtl
rtl/m2eig_pkg.sv
rtl/m2eig_isqrt.sv
rtl/matrix_2x2_eigen_decomposition.sv
rtl/m2eig_checker.sv
bench/testbench.sv
